// ===== rtl/sobel_edge_magnitude_rgb_defines.svh =====
// assertion macros shared by the sobel edge block
// expects clk and rst_n in the scope of each use
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SOBEL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobel: same-cycle check failed");
`define SOBEL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobel: next-cycle check failed");
`else
`define SOBEL_ASSERT_NOW(lbl, ante, cons)
`define SOBEL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/sobel_pkg.sv =====
// types, constants and helpers for the sobel edge magnitude block
// no dependencies
package sobel_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd768;

  // squared magnitudes above 255*255+255 round to 255 or more
  localparam logic [20:0] CLAMP_SQ = 21'd65280;
  localparam logic [7:0]  PIX_MAX  = 8'd255;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int PIX_W = 24;
  localparam int ROW_PAIR_W = 2 * PIX_W;

  typedef logic [PIX_W-1:0] pix_t;
  // [row][col], col 0 is the leftmost
  typedef pix_t [2:0][2:0] win_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_SHIFT,
    ST_DRN_RD,
    ST_CALC,
    ST_PUSH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_GRAD,
    PH_SQX,
    PH_SQY,
    PH_SUM,
    PH_ROOT,
    PH_NEXT,
    PH_DONE
  } edge_phase_t;

  typedef struct packed {
    logic start;
  } edge_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } edge_rsp_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_step;
    logic       end_of_frame;
  } out_beat_t;

  function automatic logic [7:0] chan_sel(input pix_t p, input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      2'd0:    v = p[23:16];
      2'd1:    v = p[15:8];
      default: v = p[7:0];
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/sobel_in_if.sv =====
// input pixel channel of the sobel edge block
// depends on nothing
interface sobel_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

// ===== rtl/sobel_out_if.sv =====
// result channel of the sobel edge block
// depends on nothing
interface sobel_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       last_of_step;
  logic       end_of_frame;

  modport source (output valid, edge_red, edge_green, edge_blue, last_of_step,
                  end_of_frame, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, last_of_step,
                  end_of_frame, output ready);
endinterface

// ===== rtl/sobel_cfg_if.sv =====
// configuration write channel of the sobel edge block
// depends on nothing
interface sobel_cfg_if;
  logic        valid;
  logic        ready;
  logic        reg_index;
  logic [12:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order. Both previous rows live
// in one line buffer memory (older and newer row side by side per column, MAX_WIDTH deep);
// each pixel beat reads its column and writes it back the next cycle. The results of a
// beat, a first and possibly a second, come from the shared edge unit, which handles the
// three channels one after another with one squarer and an 8-step root. A drain beat
// reads three columns through the single read port before its result is computed; an
// ignored drain beat is accepted and yields no result. A stalled sink holds a result in
// the output register and stalls the block. No clearing pass after reset.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  sobel_in_if.sink    in_bus,
  sobel_out_if.source out_bus,
  sobel_cfg_if.sink   cfg_bus
);

  localparam int IW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = (WW > sobel_pkg::FRAME_WIDTH_W) ? WW : sobel_pkg::FRAME_WIDTH_W;
  localparam int CH = (HW > sobel_pkg::FRAME_HEIGHT_W) ? HW : sobel_pkg::FRAME_HEIGHT_W;

  logic [sobel_pkg::FRAME_WIDTH_W-1:0]  frame_width_r;
  logic [sobel_pkg::FRAME_HEIGHT_W-1:0] frame_height_r;
  logic [CW-1:0] fw_ext;
  logic [CH-1:0] fh_ext;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  logic                             mem_rd_en, mem_wr_en;
  logic [IW-1:0]                    mem_rd_addr, mem_wr_addr;
  logic [sobel_pkg::ROW_PAIR_W-1:0] mem_rd_data, mem_wr_data;
  sobel_pkg::win_t      win;
  sobel_pkg::edge_req_t req;
  sobel_pkg::edge_rsp_t rsp;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= sobel_pkg::FRAME_WIDTH_RESET;
      frame_height_r <= sobel_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.reg_index)
        sobel_pkg::REG_FRAME_WIDTH:
          frame_width_r <= cfg_bus.wr_data[sobel_pkg::FRAME_WIDTH_W-1:0];
        sobel_pkg::REG_FRAME_HEIGHT:
          frame_height_r <= cfg_bus.wr_data[sobel_pkg::FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range sizes act as the nearest legal value
  assign fw_ext = CW'(frame_width_r);
  assign fh_ext = CH'(frame_height_r);
  assign eff_w  = (fw_ext == '0) ? WW'(1) :
                  (fw_ext > CW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_ext);
  assign eff_h  = (fh_ext == '0) ? HW'(1) :
                  (fh_ext > CH'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(fh_ext);

  sobel_ram #(
    .WIDTH (sobel_pkg::ROW_PAIR_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  sobel_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .win   (win),
    .req   (req),
    .rsp   (rsp)
  );

  sobel_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .win         (win),
    .req         (req),
    .rsp         (rsp)
  );

endmodule

// ===== rtl/sobel_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
module sobel_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sobel_edge.sv =====
// shared edge unit: gradients, squares and rounded root, one channel at a time
// depends on sobel_pkg
module sobel_edge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sobel_pkg::win_t      win,
  input  sobel_pkg::edge_req_t req,
  output sobel_pkg::edge_rsp_t rsp
);

  sobel_pkg::edge_phase_t phase_r, phase_nxt;

  logic [1:0]       ch_r;
  logic [2:0]       step_r;
  logic [9:0]       gx_r, gy_r;
  logic [19:0]      sqx_r, sqy_r;
  logic [15:0]      rad_r;
  logic             clamp_r;
  logic [7:0]       root_r;
  logic [10:0]      rem_r;
  logic [2:0][7:0]  res_r;

  logic [7:0]  v [3][3];
  logic [9:0]  gxp, gxn, gyp, gyn, gx_abs, gy_abs;
  logic [9:0]  mul_a;
  logic [19:0] prod;
  logic [20:0] sum;
  logic [10:0] rem_sh, trial;
  logic        take;
  logic [7:0]  rounded;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        v[i][j] = sobel_pkg::chan_sel(win[i][j], ch_r);
      end
    end
  end

  assign gxp = 10'(v[0][2]) + {1'b0, v[1][2], 1'b0} + 10'(v[2][2]);
  assign gxn = 10'(v[0][0]) + {1'b0, v[1][0], 1'b0} + 10'(v[2][0]);
  assign gyp = 10'(v[2][0]) + {1'b0, v[2][1], 1'b0} + 10'(v[2][2]);
  assign gyn = 10'(v[0][0]) + {1'b0, v[0][1], 1'b0} + 10'(v[0][2]);
  assign gx_abs = (gxp >= gxn) ? gxp - gxn : gxn - gxp;
  assign gy_abs = (gyp >= gyn) ? gyp - gyn : gyn - gyp;

  // one squarer shared by both gradients
  assign mul_a = (phase_r == sobel_pkg::PH_SQX) ? gx_r : gy_r;
  assign prod  = 20'(mul_a) * 20'(mul_a);
  assign sum   = 21'(sqx_r) + 21'(sqy_r);

  // digit-by-digit root, two radicand bits per step
  assign rem_sh  = {rem_r[8:0], rad_r[15:14]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign take    = rem_sh >= trial;
  assign rounded = clamp_r ? sobel_pkg::PIX_MAX :
                   (rem_r > 11'(root_r)) ? root_r + 8'd1 : root_r;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      sobel_pkg::PH_IDLE: if (req.start) phase_nxt = sobel_pkg::PH_GRAD;
      sobel_pkg::PH_GRAD: phase_nxt = sobel_pkg::PH_SQX;
      sobel_pkg::PH_SQX:  phase_nxt = sobel_pkg::PH_SQY;
      sobel_pkg::PH_SQY:  phase_nxt = sobel_pkg::PH_SUM;
      sobel_pkg::PH_SUM:  phase_nxt = sobel_pkg::PH_ROOT;
      sobel_pkg::PH_ROOT: if (step_r == 3'd7) phase_nxt = sobel_pkg::PH_NEXT;
      sobel_pkg::PH_NEXT: phase_nxt = (ch_r == 2'd2) ? sobel_pkg::PH_DONE
                                                     : sobel_pkg::PH_GRAD;
      sobel_pkg::PH_DONE: phase_nxt = sobel_pkg::PH_IDLE;
      default:            phase_nxt = sobel_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    rsp.busy  = phase_r != sobel_pkg::PH_IDLE;
    rsp.done  = phase_r == sobel_pkg::PH_DONE;
    rsp.red   = res_r[0];
    rsp.green = res_r[1];
    rsp.blue  = res_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sobel_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      sobel_pkg::PH_IDLE: begin
        ch_r <= 2'd0;
      end
      sobel_pkg::PH_GRAD: begin
        gx_r <= gx_abs;
        gy_r <= gy_abs;
      end
      sobel_pkg::PH_SQX: sqx_r <= prod;
      sobel_pkg::PH_SQY: sqy_r <= prod;
      sobel_pkg::PH_SUM: begin
        clamp_r <= sum > sobel_pkg::CLAMP_SQ;
        rad_r   <= sum[15:0];
        root_r  <= 8'd0;
        rem_r   <= 11'd0;
        step_r  <= 3'd0;
      end
      sobel_pkg::PH_ROOT: begin
        rad_r  <= {rad_r[13:0], 2'b00};
        step_r <= step_r + 3'd1;
        if (take) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[6:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[6:0], 1'b0};
        end
      end
      sobel_pkg::PH_NEXT: begin
        res_r[ch_r] <= rounded;
        ch_r        <= ch_r + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/sobel_ctrl.sv =====
// item sequencer: counters, window, line buffer read-modify-write, output register
// depends on sobel_pkg, the channel interfaces and the defines header
`include "sobel_edge_magnitude_rgb_defines.svh"

module sobel_ctrl #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT,
  localparam int IW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [WW-1:0]                    eff_w,
  input  logic [HW-1:0]                    eff_h,
  sobel_in_if.sink                         in_bus,
  sobel_out_if.source                      out_bus,
  output logic                             mem_rd_en,
  output logic [IW-1:0]                    mem_rd_addr,
  input  logic [sobel_pkg::ROW_PAIR_W-1:0] mem_rd_data,
  output logic                             mem_wr_en,
  output logic [IW-1:0]                    mem_wr_addr,
  output logic [sobel_pkg::ROW_PAIR_W-1:0] mem_wr_data,
  output sobel_pkg::win_t                  win,
  output sobel_pkg::edge_req_t             req,
  input  sobel_pkg::edge_rsp_t             rsp
);

  sobel_pkg::ctrl_state_t state_r, state_nxt;

  logic [IW-1:0] col_count_r, col_count_nxt;
  logic [HW-1:0] row_count_r, row_count_nxt;
  logic [IW-1:0] drain_count_r, drain_count_nxt;
  logic          out_valid_r, out_valid_nxt;

  sobel_pkg::win_t      window_r, window_nxt;
  sobel_pkg::pix_t      pix_r, pix_nxt;
  sobel_pkg::out_beat_t out_data_r, out_data_nxt;
  logic [IW-1:0] col_r, col_nxt;
  logic [IW-1:0] d_r, d_nxt;
  logic [1:0]    rd_cnt_r, rd_cnt_nxt;
  logic          row_ge1_r, row_ge1_nxt, row_ge2_r, row_ge2_nxt;
  logic          emit1_r, emit1_nxt, emit2_r, emit2_nxt;
  logic          last_r, last_nxt, eof_r, eof_nxt, pend2_r, pend2_nxt;

  logic          in_ready, accept, out_free;
  logic          frame_done, end_row, drain_go;
  logic [IW-1:0] colc;
  logic [HW-1:0] rowc;
  logic [WW-1:0] col_p1, drain_p1, dr_p1;
  logic [1:0]    dcol;
  logic          dcol_ok;
  sobel_pkg::pix_t top_pix, mid_pix;

  assign frame_done = row_count_r >= eff_h;
  assign colc       = frame_done ? '0 : col_count_r;
  assign rowc       = frame_done ? '0 : row_count_r;
  assign col_p1     = WW'(colc) + WW'(1);
  assign end_row    = col_p1 >= eff_w;
  assign drain_p1   = WW'(drain_count_r) + WW'(1);
  assign drain_go   = frame_done && (WW'(drain_count_r) < eff_w);
  assign dr_p1      = WW'(d_r) + WW'(1);
  assign accept     = in_bus.valid && in_ready;
  assign out_free   = !out_valid_r || out_bus.ready;

  // line buffer word: older row above, newer row below
  assign top_pix = row_ge2_r ? mem_rd_data[sobel_pkg::ROW_PAIR_W-1:sobel_pkg::PIX_W] : '0;
  assign mid_pix = row_ge1_r ? mem_rd_data[sobel_pkg::PIX_W-1:0] : '0;

  assign dcol    = rd_cnt_r - 2'd1;
  assign dcol_ok = (dcol == 2'd0) ? (d_r != '0) :
                   (dcol == 2'd1) ? 1'b1 : (dr_p1 < eff_w);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sobel_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_bus.cmd == sobel_pkg::CMD_PIXEL) state_nxt = sobel_pkg::ST_PIX_RD;
          else if (drain_go)                     state_nxt = sobel_pkg::ST_DRN_RD;
        end
      end
      sobel_pkg::ST_PIX_RD: begin
        if (emit1_r)      state_nxt = sobel_pkg::ST_CALC;
        else if (emit2_r) state_nxt = sobel_pkg::ST_SHIFT;
        else              state_nxt = sobel_pkg::ST_IDLE;
      end
      sobel_pkg::ST_SHIFT:  state_nxt = sobel_pkg::ST_CALC;
      sobel_pkg::ST_DRN_RD: if (rd_cnt_r == 2'd3) state_nxt = sobel_pkg::ST_CALC;
      sobel_pkg::ST_CALC:   if (rsp.done) state_nxt = sobel_pkg::ST_PUSH;
      sobel_pkg::ST_PUSH: begin
        if (out_free) state_nxt = pend2_r ? sobel_pkg::ST_SHIFT : sobel_pkg::ST_IDLE;
      end
      default: state_nxt = sobel_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = state_r == sobel_pkg::ST_IDLE;
    mem_rd_en   = 1'b0;
    mem_rd_addr = colc;
    mem_wr_en   = 1'b0;
    mem_wr_addr = col_r;
    mem_wr_data = {mid_pix, pix_r};
    req.start   = 1'b0;
    unique case (state_r)
      sobel_pkg::ST_IDLE: begin
        mem_rd_en = accept && (in_bus.cmd == sobel_pkg::CMD_PIXEL);
      end
      sobel_pkg::ST_PIX_RD: begin
        mem_wr_en = 1'b1;
        req.start = emit1_r;
      end
      sobel_pkg::ST_SHIFT: req.start = 1'b1;
      sobel_pkg::ST_DRN_RD: begin
        // columns d-1, d, d+1 of both stored rows
        mem_rd_en   = rd_cnt_r != 2'd3;
        mem_rd_addr = IW'(d_r + IW'(rd_cnt_r) - IW'(1));
        req.start   = rd_cnt_r == 2'd3;
      end
      default: ;
    endcase
  end

  always_comb begin
    col_count_nxt   = col_count_r;
    row_count_nxt   = row_count_r;
    drain_count_nxt = drain_count_r;
    out_valid_nxt   = out_valid_r;
    window_nxt      = window_r;
    pix_nxt         = pix_r;
    out_data_nxt    = out_data_r;
    col_nxt         = col_r;
    d_nxt           = d_r;
    rd_cnt_nxt      = rd_cnt_r;
    row_ge1_nxt     = row_ge1_r;
    row_ge2_nxt     = row_ge2_r;
    emit1_nxt       = emit1_r;
    emit2_nxt       = emit2_r;
    last_nxt        = last_r;
    eof_nxt         = eof_r;
    pend2_nxt       = pend2_r;

    if (out_valid_r && out_bus.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      sobel_pkg::ST_IDLE: begin
        if (accept && (in_bus.cmd == sobel_pkg::CMD_PIXEL)) begin
          pix_nxt         = {in_bus.in_red, in_bus.in_green, in_bus.in_blue};
          col_nxt         = colc;
          row_ge1_nxt     = rowc != '0;
          row_ge2_nxt     = (HW+1)'(rowc) >= (HW+1)'(2);
          emit1_nxt       = (rowc != '0) && (colc != '0);
          emit2_nxt       = (rowc != '0) && end_row;
          eof_nxt         = 1'b0;
          col_count_nxt   = end_row ? '0 : IW'(col_p1);
          row_count_nxt   = end_row ? rowc + HW'(1) : rowc;
          drain_count_nxt = frame_done ? '0 : drain_count_r;
        end else if (accept && drain_go) begin
          d_nxt      = drain_count_r;
          rd_cnt_nxt = 2'd0;
          eof_nxt    = drain_p1 == eff_w;
          if (drain_p1 >= eff_w) begin
            col_count_nxt   = '0;
            row_count_nxt   = '0;
            drain_count_nxt = '0;
          end else begin
            drain_count_nxt = IW'(drain_p1);
          end
        end
      end
      sobel_pkg::ST_PIX_RD: begin
        // first column of a row starts from an empty window
        if (col_r == '0) window_nxt = '0;
        for (int i = 0; i < 3; i++) begin
          window_nxt[i][0] = (col_r == '0) ? '0 : window_r[i][1];
          window_nxt[i][1] = (col_r == '0) ? '0 : window_r[i][2];
        end
        window_nxt[0][2] = top_pix;
        window_nxt[1][2] = mid_pix;
        window_nxt[2][2] = pix_r;
        last_nxt  = !emit2_r;
        pend2_nxt = emit1_r && emit2_r;
      end
      sobel_pkg::ST_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          window_nxt[i][0] = window_r[i][1];
          window_nxt[i][1] = window_r[i][2];
          window_nxt[i][2] = '0;
        end
        last_nxt  = 1'b1;
        pend2_nxt = 1'b0;
      end
      sobel_pkg::ST_DRN_RD: begin
        rd_cnt_nxt = rd_cnt_r + 2'd1;
        if (rd_cnt_r != 2'd0) begin
          window_nxt[0][dcol] = dcol_ok ? mem_rd_data[sobel_pkg::ROW_PAIR_W-1:sobel_pkg::PIX_W]
                                        : '0;
          window_nxt[1][dcol] = dcol_ok ? mem_rd_data[sobel_pkg::PIX_W-1:0] : '0;
          window_nxt[2][dcol] = '0;
        end
        last_nxt  = 1'b1;
        pend2_nxt = 1'b0;
      end
      sobel_pkg::ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.red          = rsp.red;
          out_data_nxt.green        = rsp.green;
          out_data_nxt.blue         = rsp.blue;
          out_data_nxt.last_of_step = last_r;
          out_data_nxt.end_of_frame = eof_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sobel_pkg::ST_IDLE;
      col_count_r   <= '0;
      row_count_r   <= '0;
      drain_count_r <= '0;
      out_valid_r   <= 1'b0;
      window_r      <= '0;
    end else begin
      state_r       <= state_nxt;
      col_count_r   <= col_count_nxt;
      row_count_r   <= row_count_nxt;
      drain_count_r <= drain_count_nxt;
      out_valid_r   <= out_valid_nxt;
      window_r      <= window_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    out_data_r <= out_data_nxt;
    col_r      <= col_nxt;
    d_r        <= d_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    row_ge1_r  <= row_ge1_nxt;
    row_ge2_r  <= row_ge2_nxt;
    emit1_r    <= emit1_nxt;
    emit2_r    <= emit2_nxt;
    last_r     <= last_nxt;
    eof_r      <= eof_nxt;
    pend2_r    <= pend2_nxt;
  end

  assign win                  = window_r;
  assign in_bus.ready         = in_ready;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.edge_red     = out_data_r.red;
  assign out_bus.edge_green   = out_data_r.green;
  assign out_bus.edge_blue    = out_data_r.blue;
  assign out_bus.last_of_step = out_data_r.last_of_step;
  assign out_bus.end_of_frame = out_data_r.end_of_frame;

  `SOBEL_ASSERT_NOW(a_start_free, req.start, !rsp.busy)
  `SOBEL_ASSERT_NOW(a_accept_quiet, in_bus.valid && in_bus.ready, !rsp.busy)
  `SOBEL_ASSERT_NEXT(a_done_push, (state_r == sobel_pkg::ST_CALC) && rsp.done, state_r == sobel_pkg::ST_PUSH)
  `SOBEL_ASSERT_NOW(a_no_write_busy, mem_wr_en, !rsp.busy && (state_r == sobel_pkg::ST_PIX_RD))

endmodule
